// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the modular exponentiation RTL.
// No dependencies; pulled in by `include inside the modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/modexp_pkg.sv =====
// Types and constants shared by the modular exponentiation block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

  localparam int FIELD_W     = 64;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_REDUCE,
    S_NEXT,
    S_MUL,
    S_ISSUE_SQ,
    S_SQUARE,
    S_FINISH
  } state_t;

  typedef enum logic {
    MM_REDUCE,
    MM_MUL
  } mm_op_t;

  typedef struct packed {
    logic   start;
    mm_op_t op;
  } mm_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

// ===== hdl/modexp_if.sv =====
// Valid/ready channel interfaces for messages in and results out.
// Depends on modexp_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface modexp_in_if;
  import modexp_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] message;
  modport source (output valid, output message, input ready);
  modport sink (input valid, input message, output ready);
endinterface

interface modexp_out_if;
  import modexp_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result;
  logic               modulus_error;
  modport source (output valid, output result, output modulus_error, input ready);
  modport sink (input valid, input result, input modulus_error, output ready);
endinterface

`default_nettype wire

// ===== hdl/modexp_mulmod.sv =====
// Bit-serial modular multiplier and reducer: one operand bit per cycle.
// Depends on modexp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module modexp_mulmod #(
  parameter int WIDTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire modexp_pkg::mm_cmd_t  cmd,
  input  wire logic [WIDTH-1:0]     a,
  input  wire logic [WIDTH-1:0]     b,
  input  wire logic [WIDTH-1:0]     n,
  output modexp_pkg::mm_stat_t      stat,
  output logic [WIDTH-1:0]          product
);
  import modexp_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy;
  logic             done;
  mm_op_t           op;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] mult;

  logic [WIDTH:0]   n_ext;
  logic [WIDTH:0]   add_sum;
  logic [WIDTH:0]   add_red;
  logic [WIDTH-1:0] dbl_in;
  logic             dbl_bit;
  logic [WIDTH:0]   dbl_sum;
  logic [WIDTH:0]   dbl_red;

  always_comb begin
    n_ext   = {1'b0, n};
    add_sum = {1'b0, acc} + {1'b0, addend};
    add_red = (add_sum >= n_ext) ? add_sum - n_ext : add_sum;
    dbl_in  = (op == MM_REDUCE) ? acc : addend;
    dbl_bit = (op == MM_REDUCE) ? mult[WIDTH-1] : 1'b0;
    dbl_sum = {dbl_in, dbl_bit};
    dbl_red = (dbl_sum >= n_ext) ? dbl_sum - n_ext : dbl_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op     <= cmd.op;
      acc    <= '0;
      addend <= a;
      mult   <= b;
    end else if (busy) begin
      if (op == MM_REDUCE) begin
        acc  <= dbl_red[WIDTH-1:0];
        mult <= {mult[WIDTH-2:0], 1'b0};
      end else begin
        if (mult[0]) begin
          acc <= add_red[WIDTH-1:0];
        end
        addend <= dbl_red[WIDTH-1:0];
        mult   <= {1'b0, mult[WIDTH-1:1]};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

  `ASSERT_IMPLY(a_start_idle, clk, rst, cmd.start, !busy, "start while busy")
  `ASSERT_IMPLY(a_acc_below_n, clk, rst, busy, acc < n, "partial product not reduced")
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy, "done not a single pulse")

endmodule

`default_nettype wire

// ===== hdl/modular_exponentiation_top.sv =====
// Modular exponentiation top level: key registers, square-and-multiply sequencer.
// Depends on modexp_pkg, modexp_if, modexp_mulmod and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Write modulus (index 0) and exponent (index 1) through write_enable,
//   write_index and write_data while the block is idle. Messages arrive on
//   in_ch, one beat per message; each yields one beat on out_ch carrying
//   result = message^exponent mod modulus and modulus_error.
//   One message is worked at a time; in_ch.ready is high only while idle.
//   The message is first reduced, then each exponent bit up to the highest
//   set one costs one square plus, for a set bit, one multiply, all on a
//   single bit-serial modular multiplier. A zero exponent or a zero
//   modulus bypasses the multiplier and goes straight to the output.
//   The result sits in an output register; a stalled out_ch holds it and
//   a finished next result waits for the slot to free.
//   Synchronous reset clears both key registers to zero and drops any
//   work in progress and any pending output beat.

module modular_exponentiation_top #(
  parameter int WIDTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                write_enable,
  input  wire logic [modexp_pkg::CFG_INDEX_W-1:0]  write_index,
  input  wire logic [modexp_pkg::FIELD_W-1:0]      write_data,
  modexp_in_if.sink                                in_ch,
  modexp_out_if.source                             out_ch
);
  import modexp_pkg::*;
  `include "assert_macros.svh"

  logic [WIDTH-1:0]   modulus_reg;
  logic [WIDTH-1:0]   exponent_reg;

  state_t             state;
  state_t             state_next;

  logic [WIDTH-1:0]   msg;
  logic [WIDTH-1:0]   n_val;
  logic [WIDTH-1:0]   e_bits;
  logic [WIDTH-1:0]   acc;
  logic [WIDTH-1:0]   base;
  logic               err;

  logic               out_valid;
  logic [FIELD_W-1:0] out_result;
  logic               out_err;

  mm_cmd_t            mm_cmd;
  mm_stat_t           mm_stat;
  logic [WIDTH-1:0]   mm_a;
  logic [WIDTH-1:0]   mm_b;
  logic [WIDTH-1:0]   mm_p;

  logic               accept;
  logic               special;
  logic               slot_free;
  logic               ld_base;
  logic               ld_acc;
  logic               ld_out;

  assign accept    = in_ch.valid && in_ch.ready;
  assign special   = (e_bits == '0) || (n_val == '0);
  assign slot_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_reg  <= '0;
      exponent_reg <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_MODULUS:  modulus_reg  <= write_data[WIDTH-1:0];
        REG_EXPONENT: exponent_reg <= write_data[WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (accept) state_next = S_SETUP;
      S_SETUP:    state_next = special ? S_FINISH : S_REDUCE;
      S_REDUCE:   if (mm_stat.done) state_next = S_NEXT;
      S_NEXT: begin
        if (e_bits == '0) begin
          state_next = S_FINISH;
        end else if (e_bits[0]) begin
          state_next = S_MUL;
        end else begin
          state_next = S_SQUARE;
        end
      end
      S_MUL:      if (mm_stat.done) state_next = S_ISSUE_SQ;
      S_ISSUE_SQ: state_next = S_SQUARE;
      S_SQUARE:   if (mm_stat.done) state_next = S_NEXT;
      S_FINISH:   if (slot_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    mm_cmd.start = 1'b0;
    mm_cmd.op    = MM_MUL;
    mm_a         = base;
    mm_b         = base;
    ld_base      = 1'b0;
    ld_acc       = 1'b0;
    ld_out       = 1'b0;
    case (state)
      S_IDLE:     in_ch.ready = 1'b1;
      S_SETUP: begin
        mm_cmd.start = !special;
        mm_cmd.op    = MM_REDUCE;
        mm_b         = msg;
      end
      S_REDUCE:   ld_base = mm_stat.done;
      S_NEXT: begin
        mm_cmd.start = (e_bits != '0);
        if (e_bits[0]) begin
          mm_a = acc;
        end
      end
      S_MUL:      ld_acc = mm_stat.done;
      S_ISSUE_SQ: mm_cmd.start = 1'b1;
      S_SQUARE:   ld_base = mm_stat.done;
      S_FINISH:   ld_out = slot_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg    <= in_ch.message[WIDTH-1:0];
      n_val  <= modulus_reg;
      e_bits <= exponent_reg;
    end else if (state == S_SQUARE && mm_stat.done) begin
      e_bits <= {1'b0, e_bits[WIDTH-1:1]};
    end
    if (state == S_SETUP) begin
      err <= (e_bits != '0) && (n_val == '0);
      if (e_bits == '0) begin
        acc <= WIDTH'(1);
      end else if (n_val <= WIDTH'(1)) begin
        acc <= '0;
      end else begin
        acc <= WIDTH'(1);
      end
    end else if (ld_acc) begin
      acc <= mm_p;
    end
    if (ld_base) begin
      base <= mm_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_result <= FIELD_W'(acc);
      out_err    <= err;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.result        = out_result;
  assign out_ch.modulus_error = out_err;

  modexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mm_cmd),
    .a       (mm_a),
    .b       (mm_b),
    .n       (n_val),
    .stat    (mm_stat),
    .product (mm_p)
  );

  `ASSERT_IMPLY(a_err_zero, clk, rst, out_valid && out_err, out_result == '0,
                "error beat with nonzero result")
  `ASSERT_IMPLY(a_unit_active, clk, rst,
                state == S_REDUCE || state == S_MUL || state == S_SQUARE,
                mm_stat.busy || mm_stat.done, "waiting on idle multiplier")
  `ASSERT_IMPLY(a_operands_reduced, clk, rst, state == S_NEXT,
                acc < n_val && base < n_val, "operands not below modulus")

endmodule

`default_nettype wire

// ===== test/modular_exponentiation_top_tb.sv =====
// Self-checking bench for the modular exponentiation top level: keys over the write port,
// messages in and results out on valid/ready channels, checked against a square-and-multiply
// predictor. Depends on modexp_pkg, modexp_if and modular_exponentiation_top.
`timescale 1ns / 1ps

module modular_exponentiation_top_tb;
  import modexp_pkg::*;

  localparam int OP_W = 64;
  localparam logic [63:0] OP_MASK = {64{1'b1}} >> (64 - OP_W);
  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  typedef struct packed {
    logic [FIELD_W-1:0] result;
    logic               modulus_error;
  } modexp_beat_t;

  logic                   clk;
  logic                   rst;
  logic                   write_enable;
  logic [CFG_INDEX_W-1:0] write_index;
  logic [FIELD_W-1:0]     write_data;

  modexp_in_if  in_ch();
  modexp_out_if out_ch();

  modular_exponentiation_top #(.WIDTH(OP_W)) DUT (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

  logic [63:0]  pending_messages[$];
  logic [63:0]  phase_msgs[$];
  modexp_beat_t awaited_results[$];
  logic [63:0]  key_modulus;
  logic [63:0]  key_exponent;
  int           idle_in_pct;
  int           stall_out_pct;
  int           error_count;
  int           checked_count;
  int           setting_count;
  logic         in_taken;

  function automatic logic [63:0] add_reduce(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[63:0];
  endfunction

  function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] addend;
    acc = '0;
    addend = a;
    for (int i = 0; i < OP_W; i++) begin
      if (b[i]) acc = add_reduce(acc, addend, n);
      addend = add_reduce(addend, addend, n);
    end
    return acc;
  endfunction

  function automatic modexp_beat_t modexp_predict(logic [63:0] message);
    modexp_beat_t beat;
    logic [63:0]  n;
    logic [63:0]  e;
    logic [63:0]  base;
    n = key_modulus & OP_MASK;
    e = key_exponent & OP_MASK;
    beat.modulus_error = 1'b0;
    if (e == 0) begin
      beat.result = 64'd1;
    end else if (n == 0) begin
      beat.result = '0;
      beat.modulus_error = 1'b1;
    end else begin
      base = (message & OP_MASK) % n;
      beat.result = 64'd1 % n;
      for (int i = 0; i < OP_W; i++) begin
        if (e[i]) beat.result = mul_reduce(beat.result, base, n);
        base = mul_reduce(base, base, n);
      end
    end
    return beat;
  endfunction

  function automatic logic [63:0] rand_bits(int nbits);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (nbits < 64) v = v & ((64'd1 << nbits) - 64'd1);
    v[nbits-1] = 1'b1;
    return v;
  endfunction

  function automatic logic [63:0] pick_message(logic [63:0] n);
    case ($urandom_range(19))
      0: return '0;
      1: return 64'd1;
      2: return ALL_ONES;
      3: return n - 64'd1;
      4: return n;
      5: return n + 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_messages.size() != 0 || in_ch.valid || awaited_results.size() != 0);
  endtask

  task automatic apply_setting(input bit write_keys, input logic [63:0] n,
                               input logic [63:0] e, input int pause_at);
    wait_drained();
    repeat (4) @(negedge clk);
    if (write_keys) begin
      write_enable = 1'b1;
      write_index  = REG_MODULUS;
      write_data   = n;
      key_modulus  = n;
      @(negedge clk);
      write_index  = REG_EXPONENT;
      write_data   = e;
      key_exponent = e;
      @(negedge clk);
      write_enable = 1'b0;
    end
    case (setting_count % 4)
      0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
      1: begin idle_in_pct = 72; stall_out_pct = 0;  end
      2: begin idle_in_pct = 0;  stall_out_pct = 72; end
      default: begin idle_in_pct = 24; stall_out_pct = 24; end
    endcase
    setting_count++;
    for (int j = 0; j < phase_msgs.size(); j++) begin
      if (j == pause_at && j != 0) wait_drained();
      pending_messages.push_back(phase_msgs[j]);
    end
    phase_msgs.delete();
  endtask

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #100_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_messages.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.message <= pending_messages.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= stall_out_pct);
  end

  always @(posedge clk) begin : monitor
    modexp_beat_t want;
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready)
      awaited_results.push_back(modexp_predict(in_ch.message));
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h err %b", out_ch.result,
                                  out_ch.modulus_error));
      end else begin
        want = awaited_results.pop_front();
        checked_count++;
        if (out_ch.result !== want.result)
          report_mismatch($sformatf("result %h, want %h", out_ch.result, want.result));
        if (out_ch.modulus_error !== want.modulus_error)
          report_mismatch($sformatf("modulus_error %b, want %b", out_ch.modulus_error,
                                    want.modulus_error));
      end
    end
  end

  initial begin : stimulus
    logic [63:0] n;
    logic [63:0] e;
    int          count;
    rst           = 1'b1;
    write_enable  = 1'b0;
    write_index   = REG_MODULUS;
    write_data    = '0;
    in_ch.valid   = 1'b0;
    in_ch.message = '0;
    out_ch.ready  = 1'b0;
    in_taken      = 1'b0;
    key_modulus   = '0;
    key_exponent  = '0;
    idle_in_pct   = 0;
    stall_out_pct = 0;
    error_count   = 0;
    checked_count = 0;
    setting_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // keys at reset: zero exponent and zero modulus
    phase_msgs = '{64'd0, ALL_ONES};
    apply_setting(1'b0, '0, '0, 0);
    // zero modulus with a nonzero exponent
    phase_msgs = '{64'd7, ALL_ONES};
    apply_setting(1'b1, '0, 64'd5, 0);
    // zero exponent with modulus one, then modulus one with a real exponent
    phase_msgs = '{64'd123};
    apply_setting(1'b1, 64'd1, '0, 0);
    phase_msgs = '{64'd123};
    apply_setting(1'b1, 64'd1, 64'd3, 0);
    // full-length modulus and exponent, with a drain in the middle
    phase_msgs = '{64'd0, 64'd1, ALL_ONES, ALL_ONES - 64'd1, 64'd2};
    apply_setting(1'b1, ALL_ONES, ALL_ONES, 2);
    // top exponent bit only; messages at and above the modulus
    n = 64'hFFFF_FFFF_FFFF_FFC5;
    phase_msgs = '{64'd3, n, n + 64'd1};
    apply_setting(1'b1, n, 64'h8000_0000_0000_0000, 0);
    // even modulus with only the top bit set
    phase_msgs = '{64'h0123_4567_89AB_CDEF, ALL_ONES, 64'h8000_0000_0000_0001};
    apply_setting(1'b1, 64'h8000_0000_0000_0000, 64'd65537, 0);
    phase_msgs = '{64'd0, 64'd2, 64'd3, 64'd4};
    apply_setting(1'b1, 64'd3, 64'd1, 0);

    for (int s = 0; s < 8; s++) begin
      case ($urandom_range(9))
        0: n = '0;
        1: n = 64'd1;
        2: n = $urandom_range(1000, 2);
        3: n = 64'd1 << $urandom_range(63);
        4: n = ALL_ONES;
        default: n = rand_bits($urandom_range(64, 2));
      endcase
      if (s == 3) begin
        e = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
      end else begin
        case ($urandom_range(9))
          0: e = '0;
          1: e = 64'd1;
          default: e = rand_bits($urandom_range(16, 1));
        endcase
      end
      count = $urandom_range(12, 8);
      for (int k = 0; k < count; k++) phase_msgs.push_back(pick_message(n));
      apply_setting(1'b1, n, e, $urandom_range(count - 1, 1));
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    $display("Checked %0d results over %0d key settings, all four idle patterns,",
             checked_count, setting_count);
    $display("zero and full-width keys, and messages at or above the modulus.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
